// ===== design/ihsp_pkg.sv =====
// Shared types and constants for the image header size parser.
`timescale 1ns / 1ps

package ihsp_pkg;

    // Byte position counter width
    localparam int POSITION_BITS = 32;

    typedef logic [POSITION_BITS-1:0] pos_t;
    typedef logic [POSITION_BITS:0]   pos_ext_t;

    localparam int HDR_LEN = 24;
    localparam int WIN_LEN = 12;

    // Segment walk starts at this byte, first segment header begins at byte 2
    localparam int WALK_START_IDX = 13;
    localparam int SEG_START_INIT = 2;
    localparam int CAP_POS_INIT   = SEG_START_INIT + WIN_LEN - 1;

    localparam pos_t POS_MAX = '1;

    // Marker and signature bytes
    localparam logic [7:0] BYTE_FF    = 8'hFF;
    localparam logic [7:0] BYTE_SOI   = 8'hD8;
    localparam logic [7:0] BYTE_APP0  = 8'hE0;
    localparam logic [7:0] SOF_LO_A   = 8'hC0;
    localparam logic [7:0] SOF_HI_A   = 8'hC3;
    localparam logic [7:0] SOF_LO_B   = 8'hC9;
    localparam logic [7:0] SOF_HI_B   = 8'hCB;
    localparam logic [7:0] PNG_SIG0   = 8'h89;
    localparam logic [7:0] BYTE_CR    = 8'h0D;
    localparam logic [7:0] BYTE_LF    = 8'h0A;
    localparam logic [7:0] BYTE_SUB   = 8'h1A;
    localparam logic [7:0] CHR_J      = 8'h4A;
    localparam logic [7:0] CHR_F      = 8'h46;
    localparam logic [7:0] CHR_I      = 8'h49;
    localparam logic [7:0] CHR_G      = 8'h47;
    localparam logic [7:0] CHR_P      = 8'h50;
    localparam logic [7:0] CHR_N      = 8'h4E;
    localparam logic [7:0] CHR_H      = 8'h48;
    localparam logic [7:0] CHR_D      = 8'h44;
    localparam logic [7:0] CHR_R      = 8'h52;

    typedef enum logic [1:0] {
        FMT_NONE = 2'd0,
        FMT_JPEG = 2'd1,
        FMT_GIF  = 2'd2,
        FMT_PNG  = 2'd3
    } fmt_t;

endpackage

// ===== design/image_header_size_parser_top.sv =====
// Image header size parser: streaming byte parser for JPEG, GIF and PNG dimensions.
// Result path: the last byte waits in the input register, and the result register
//   loads when that byte is processed.
// Throughput: one byte per cycle; a held result stalls only a following last byte.
// Reset (rst_n, async, active low) clears position, walk state and both valid flags;
//   after every last byte the parser returns to its reset state on its own.
`timescale 1ns / 1ps

module image_header_size_parser_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        found,
    output logic [1:0]  image_format,
    output logic [31:0] width,
    output logic [31:0] height
);

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic       in_valid_reg, in_valid_next;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic       proc_fire;

    // A non-last byte always moves on; a last byte needs room in the result register.
    assign proc_fire = in_valid_reg && (!last_reg || !out_valid || out_ready);
    assign in_ready  = !in_valid_reg || proc_fire;

    always_comb
    begin
        if (in_valid && in_ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (proc_fire)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= data_byte;
            last_reg <= last_byte;
        end
    end

    // ------------------------------------------------------------------
    // Parser state
    // ------------------------------------------------------------------
    ihsp_pkg::pos_t pos_reg, pos_next;
    ihsp_pkg::pos_t cap_pos_reg, cap_pos_next;   // next segment start + 11
    logic           walk_reg, walk_next;
    logic           ovf_reg, ovf_next;

    logic [7:0] hdr_reg [ihsp_pkg::HDR_LEN];
    logic [7:0] stg_reg [ihsp_pkg::WIN_LEN];
    logic [7:0] seg_reg [ihsp_pkg::WIN_LEN];
    logic [7:0] stg_new [ihsp_pkg::WIN_LEN];
    logic [7:0] seg_new [ihsp_pkg::WIN_LEN];

    logic                 jfif;
    logic                 walk_set;
    logic                 capture;
    logic                 seg_stop;
    logic [15:0]          seg_len;
    ihsp_pkg::pos_ext_t   seg_sum;
    logic                 at_max;

    // Staging window after shifting in the current byte
    always_comb
    begin
        for (int i = 0; i < ihsp_pkg::WIN_LEN - 1; i++)
        begin
            stg_new[i] = stg_reg[i+1];
        end
        stg_new[ihsp_pkg::WIN_LEN-1] = byte_reg;
    end

    // JFIF signature in header bytes 0..9 (bytes 4 and 5 are the APP0 length)
    assign jfif = (hdr_reg[0] == ihsp_pkg::BYTE_FF)   && (hdr_reg[1] == ihsp_pkg::BYTE_SOI) &&
                  (hdr_reg[2] == ihsp_pkg::BYTE_FF)   && (hdr_reg[3] == ihsp_pkg::BYTE_APP0) &&
                  (hdr_reg[6] == ihsp_pkg::CHR_J)     && (hdr_reg[7] == ihsp_pkg::CHR_F) &&
                  (hdr_reg[8] == ihsp_pkg::CHR_I)     && (hdr_reg[9] == ihsp_pkg::CHR_F);

    assign walk_set = walk_reg ||
                      ((pos_reg == ihsp_pkg::pos_t'(ihsp_pkg::WALK_START_IDX)) && jfif);
    assign capture  = walk_set && (pos_reg == cap_pos_reg);

    // Segment length and next capture point; carry out means the walk leaves the range
    assign seg_len = {stg_new[2], stg_new[3]};
    assign seg_sum = {1'b0, cap_pos_reg} + ihsp_pkg::pos_ext_t'(seg_len) +
                     ihsp_pkg::pos_ext_t'(ihsp_pkg::SEG_START_INIT);

    always_comb
    begin
        seg_stop = (stg_new[0] != ihsp_pkg::BYTE_FF) ||
                   ((stg_new[1] >= ihsp_pkg::SOF_LO_A) && (stg_new[1] <= ihsp_pkg::SOF_HI_A)) ||
                   ((stg_new[1] >= ihsp_pkg::SOF_LO_B) && (stg_new[1] <= ihsp_pkg::SOF_HI_B)) ||
                   seg_sum[ihsp_pkg::POSITION_BITS];
    end

    always_comb
    begin
        for (int i = 0; i < ihsp_pkg::WIN_LEN; i++)
        begin
            seg_new[i] = capture ? stg_new[i] : seg_reg[i];
        end
    end

    assign at_max = (pos_reg == ihsp_pkg::POS_MAX);

    // Control next state; everything returns to reset after a last byte
    always_comb
    begin
        pos_next     = pos_reg;
        cap_pos_next = cap_pos_reg;
        walk_next    = walk_reg;
        ovf_next     = ovf_reg;
        if (proc_fire)
        begin
            if (last_reg)
            begin
                pos_next     = '0;
                cap_pos_next = ihsp_pkg::pos_t'(ihsp_pkg::CAP_POS_INIT);
                walk_next    = 1'b0;
                ovf_next     = 1'b0;
            end
            else
            begin
                pos_next  = at_max ? pos_reg : pos_reg + 1'b1;
                ovf_next  = ovf_reg || at_max;
                walk_next = walk_set && !(capture && seg_stop);
                if (capture && !seg_stop)
                begin
                    cap_pos_next = seg_sum[ihsp_pkg::POSITION_BITS-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            cap_pos_reg <= ihsp_pkg::pos_t'(ihsp_pkg::CAP_POS_INIT);
            walk_reg    <= 1'b0;
            ovf_reg     <= 1'b0;
        end
        else
        begin
            pos_reg     <= pos_next;
            cap_pos_reg <= cap_pos_next;
            walk_reg    <= walk_next;
            ovf_reg     <= ovf_next;
        end
    end

    // Byte stores: header keeps the first bytes, staging shifts, segment captures
    always_ff @(posedge clk)
    begin
        if (proc_fire)
        begin
            for (int i = 0; i < ihsp_pkg::HDR_LEN; i++)
            begin
                if (pos_reg == ihsp_pkg::pos_t'(i))
                begin
                    hdr_reg[i] <= byte_reg;
                end
            end
            for (int i = 0; i < ihsp_pkg::WIN_LEN; i++)
            begin
                stg_reg[i] <= stg_new[i];
                if (capture)
                begin
                    seg_reg[i] <= stg_new[i];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result decode
    // ------------------------------------------------------------------
    logic [7:0]       buf_b [ihsp_pkg::HDR_LEN];
    logic             res_ok;
    ihsp_pkg::fmt_t   fmt_next;
    logic [31:0]      width_next, height_next;

    // Enough bytes and no counter overflow on this file
    assign res_ok = !(ovf_reg || at_max) &&
                    (pos_reg >= ihsp_pkg::pos_t'(ihsp_pkg::HDR_LEN - 1));

    // Header view: current byte fills the final slot, JFIF overlays the segment window
    always_comb
    begin
        for (int i = 0; i < ihsp_pkg::HDR_LEN; i++)
        begin
            buf_b[i] = hdr_reg[i];
        end
        if (pos_reg == ihsp_pkg::pos_t'(ihsp_pkg::HDR_LEN - 1))
        begin
            buf_b[ihsp_pkg::HDR_LEN-1] = byte_reg;
        end
        if (jfif)
        begin
            for (int i = 0; i < ihsp_pkg::WIN_LEN; i++)
            begin
                buf_b[i+2] = seg_new[i];
            end
        end
    end

    always_comb
    begin
        fmt_next    = ihsp_pkg::FMT_NONE;
        width_next  = '0;
        height_next = '0;
        if (res_ok)
        begin
            if ((buf_b[0] == ihsp_pkg::BYTE_FF) && (buf_b[1] == ihsp_pkg::BYTE_SOI) &&
                (buf_b[2] == ihsp_pkg::BYTE_FF))
            begin
                fmt_next    = ihsp_pkg::FMT_JPEG;
                height_next = {16'h0000, buf_b[7], buf_b[8]};
                width_next  = {16'h0000, buf_b[9], buf_b[10]};
            end
            else if ((buf_b[0] == ihsp_pkg::CHR_G) && (buf_b[1] == ihsp_pkg::CHR_I) &&
                     (buf_b[2] == ihsp_pkg::CHR_F))
            begin
                fmt_next    = ihsp_pkg::FMT_GIF;
                width_next  = {16'h0000, buf_b[7], buf_b[6]};
                height_next = {16'h0000, buf_b[9], buf_b[8]};
            end
            else if ((buf_b[0] == ihsp_pkg::PNG_SIG0) && (buf_b[1] == ihsp_pkg::CHR_P) &&
                     (buf_b[2] == ihsp_pkg::CHR_N)    && (buf_b[3] == ihsp_pkg::CHR_G) &&
                     (buf_b[4] == ihsp_pkg::BYTE_CR)  && (buf_b[5] == ihsp_pkg::BYTE_LF) &&
                     (buf_b[6] == ihsp_pkg::BYTE_SUB) && (buf_b[7] == ihsp_pkg::BYTE_LF) &&
                     (buf_b[12] == ihsp_pkg::CHR_I)   && (buf_b[13] == ihsp_pkg::CHR_H) &&
                     (buf_b[14] == ihsp_pkg::CHR_D)   && (buf_b[15] == ihsp_pkg::CHR_R))
            begin
                fmt_next    = ihsp_pkg::FMT_PNG;
                width_next  = {buf_b[16], buf_b[17], buf_b[18], buf_b[19]};
                height_next = {buf_b[20], buf_b[21], buf_b[22], buf_b[23]};
            end
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic           out_valid_reg, out_valid_next;
    ihsp_pkg::fmt_t fmt_reg;
    logic [31:0]    width_reg, height_reg;
    logic           res_load;

    assign res_load = proc_fire && last_reg;

    always_comb
    begin
        if (res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            fmt_reg    <= fmt_next;
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign found        = (fmt_reg != ihsp_pkg::FMT_NONE);
    assign image_format = fmt_reg;
    assign width        = width_reg;
    assign height       = height_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_no_size_without_format: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> (width == 32'h0) && (height == 32'h0))
        else $error("size reported without a recognized format");

    a_restart_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        proc_fire && last_reg |=> (pos_reg == '0) && !walk_reg && !ovf_reg &&
        (cap_pos_reg == ihsp_pkg::pos_t'(ihsp_pkg::CAP_POS_INIT)))
        else $error("parser state not restored after last byte");

    a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !res_load)
        else $error("held result overwritten");

endmodule
